FILE: rtl/core/rectangle_class_matcher_unit_defines.svh
// Assertion helpers for the rectangle class matcher.
`ifndef RECTANGLE_CLASS_MATCHER_UNIT_DEFINES_SVH
`define RECTANGLE_CLASS_MATCHER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcm: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define RCM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcm: next-cycle check failed");

`endif

FILE: rtl/core/rcm_pkg.sv
`timescale 1ns / 1ps

package rcm_pkg;

    localparam int FUNC_W       = 2;
    localparam int COORD_PORT_W = 16;
    localparam int ID_W         = 8;
    localparam int LIMIT_W      = 15;
    localparam int TALLY_W      = 16;
    localparam int USED_W       = 9;
    localparam int ASG_W        = 8;
    localparam int SEEN_W       = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd250;
    localparam logic [TALLY_W-1:0] TALLY_MAX   = '1;
    localparam logic [SEEN_W-1:0]  SEEN_MAX    = '1;

    typedef enum logic [FUNC_W-1:0] {
        F_CLASSIFY = 2'd0,
        F_TALLY    = 2'd1,
        F_READ     = 2'd2,
        F_RESTART  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TALLY_RD,
        S_TALLY_UPD,
        S_FINISH
    } t_state;

endpackage

FILE: rtl/core/rcm_match_unit.sv
`timescale 1ns / 1ps

module rcm_match_unit
    import rcm_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic [4*COORD_BITS-1:0] i_outline,
    input  logic [4*COORD_BITS-1:0] i_entry,
    input  logic [LIMIT_W-1:0]      i_limit,
    output logic                    o_match
);

    // Wide enough for both magnitude and limit, with room for a zero pad on each.
    localparam int CMP_W = ((COORD_BITS + 1 > LIMIT_W) ? COORD_BITS + 1 : LIMIT_W) + 1;

    logic [COORD_BITS:0] diff [4];
    logic [COORD_BITS:0] mag  [4];
    logic [3:0]          lane_ok;
    logic [CMP_W-1:0]    limit_ext;

    assign limit_ext = CMP_W'(i_limit);

    // Largest difference below the limit is the same as every difference below it.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            diff[k] = {i_outline[k*COORD_BITS + COORD_BITS - 1],
                       i_outline[k*COORD_BITS +: COORD_BITS]}
                    - {i_entry[k*COORD_BITS + COORD_BITS - 1],
                       i_entry[k*COORD_BITS +: COORD_BITS]};
            mag[k]     = diff[k][COORD_BITS] ? (~diff[k] + 1'b1) : diff[k];
            lane_ok[k] = CMP_W'(mag[k]) < limit_ext;
        end
    end

    assign o_match = &lane_ok;

endmodule

FILE: rtl/core/rectangle_class_matcher_unit.sv
`timescale 1ns / 1ps
// Classify walks the stored classes one per cycle through a single match unit fed by the
// registered read port of the rectangle memory: a hit ends the walk at the matching entry,
// a miss once every stored class has been read and compared (with no read on an empty table).
// Tally and read go through tally memory read, update and output; restart goes straight to output.
// One item at a time: the input is ready again in the cycle the result is presented.
// Synchronous active-low reset empties the table and counters; no memory clearing pass.
`include "rectangle_class_matcher_unit_defines.svh"

module rectangle_class_matcher_unit
    import rcm_pkg::*;
#(
    parameter int MAX_CLASSES = 256,
    parameter int COORD_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [LIMIT_W-1:0]      i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [FUNC_W-1:0]       i_func,
    input  logic [COORD_PORT_W-1:0] i_min_x,
    input  logic [COORD_PORT_W-1:0] i_min_y,
    input  logic [COORD_PORT_W-1:0] i_max_x,
    input  logic [COORD_PORT_W-1:0] i_max_y,
    input  logic [ID_W-1:0]         i_class_id,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [ASG_W-1:0]        o_assigned_class,
    output logic                    o_new_class,
    output logic                    o_table_full,
    output logic [TALLY_W-1:0]      o_tally,
    output logic [USED_W-1:0]       o_classes_used,
    output logic [SEEN_W-1:0]       o_outlines_seen
);

    localparam int IDX_W   = $clog2(MAX_CLASSES);
    localparam int FILL_W  = $clog2(MAX_CLASSES + 1);
    localparam int RECT_W  = 4 * COORD_BITS;
    localparam int IDC_W   = (FILL_W > ID_W) ? FILL_W : ID_W;
    localparam int AE_W    = (IDX_W > ASG_W) ? IDX_W : ASG_W;
    localparam int UE_W    = (FILL_W > USED_W) ? FILL_W : USED_W;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_CLASSES);

    logic [RECT_W-1:0]  rect_mem  [MAX_CLASSES];
    logic [TALLY_W-1:0] tally_mem [MAX_CLASSES];

    t_state             r_state, n_state;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [SEEN_W-1:0]  r_seen, n_seen;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_out_valid;
    logic               r_cmp_vld;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic [FILL_W-1:0]  r_addr, n_addr;
    t_func              r_func, n_func;
    logic [ID_W-1:0]    r_id, n_id;
    logic [RECT_W-1:0]  r_outline, n_outline;
    logic [RECT_W-1:0]  r_rect_rd;
    logic [TALLY_W-1:0] r_tally_rd;
    logic [ASG_W-1:0]   r_res_asg, n_res_asg;
    logic               r_res_new, n_res_new;
    logic               r_res_full, n_res_full;
    logic [TALLY_W-1:0] r_res_tally, n_res_tally;

    logic [ASG_W-1:0]   r_o_asg;
    logic               r_o_new;
    logic               r_o_full;
    logic [TALLY_W-1:0] r_o_tally;
    logic [USED_W-1:0]  r_o_used;
    logic [SEEN_W-1:0]  r_o_seen;

    logic               in_xfer, out_free, out_load;
    logic               match, hit, miss, issue;
    logic               rect_we, tally_we;
    logic [IDX_W-1:0]   tally_waddr;
    logic [TALLY_W-1:0] tally_wdata, tally_inc;
    logic [IDX_W-1:0]   addr_idx, fill_idx, id_idx;
    logic [IDC_W-1:0]   id_ext;
    logic               id_ok;
    logic [AE_W-1:0]    cmp_idx_ext, fill_idx_ext;
    logic [UE_W-1:0]    used_ext;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign addr_idx     = r_addr[IDX_W-1:0];
    assign fill_idx     = r_fill[IDX_W-1:0];
    assign id_ext       = IDC_W'(r_id);
    assign id_idx       = id_ext[IDX_W-1:0];
    assign id_ok        = id_ext < IDC_W'(r_fill);
    assign cmp_idx_ext  = AE_W'(r_cmp_idx);
    assign fill_idx_ext = AE_W'(fill_idx);
    assign used_ext     = UE_W'(r_fill);
    assign tally_inc    = (r_tally_rd == TALLY_MAX) ? r_tally_rd : r_tally_rd + 1'b1;

    rcm_match_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_match (
        .i_outline (r_outline),
        .i_entry   (r_rect_rd),
        .i_limit   (r_limit),
        .o_match   (match)
    );

    assign hit   = (r_state == S_SCAN) && r_cmp_vld && match;
    assign issue = (r_state == S_SCAN) && (r_addr < r_fill) && !hit;
    assign miss  = (r_state == S_SCAN) && !r_cmp_vld && !(r_addr < r_fill);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (t_func'(i_func))
                        F_CLASSIFY:     n_state = S_SCAN;
                        F_TALLY, F_READ: n_state = S_TALLY_RD;
                        F_RESTART:      n_state = S_FINISH;
                        default:        n_state = S_FINISH;
                    endcase
                end
            end
            S_SCAN: begin
                if (hit || miss) n_state = S_FINISH;
            end
            S_TALLY_RD:  n_state = S_TALLY_UPD;
            S_TALLY_UPD: n_state = S_FINISH;
            S_FINISH: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        n_addr      = r_addr;
        n_fill      = r_fill;
        n_seen      = r_seen;
        n_func      = r_func;
        n_id        = r_id;
        n_outline   = r_outline;
        n_res_asg   = r_res_asg;
        n_res_new   = r_res_new;
        n_res_full  = r_res_full;
        n_res_tally = r_res_tally;
        rect_we     = 1'b0;
        tally_we    = 1'b0;
        tally_waddr = fill_idx;
        tally_wdata = '0;
        out_load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_func      = t_func'(i_func);
                    n_id        = i_class_id;
                    n_outline   = {i_max_y[COORD_BITS-1:0], i_max_x[COORD_BITS-1:0],
                                   i_min_y[COORD_BITS-1:0], i_min_x[COORD_BITS-1:0]};
                    n_addr      = '0;
                    n_res_asg   = '0;
                    n_res_new   = 1'b0;
                    n_res_full  = 1'b0;
                    n_res_tally = '0;
                    if (t_func'(i_func) == F_CLASSIFY) begin
                        if (r_seen != SEEN_MAX) n_seen = r_seen + 1'b1;
                    end else if (t_func'(i_func) == F_RESTART) begin
                        n_fill = '0;
                        n_seen = '0;
                    end
                end
            end
            S_SCAN: begin
                if (issue) n_addr = r_addr + 1'b1;
                if (hit) begin
                    n_res_asg = cmp_idx_ext[ASG_W-1:0];
                end else if (miss) begin
                    if (r_fill < FILL_MAX) begin
                        // store the outline as a new class with a zero tally
                        rect_we   = 1'b1;
                        tally_we  = 1'b1;
                        n_res_asg = fill_idx_ext[ASG_W-1:0];
                        n_res_new = 1'b1;
                        n_fill    = r_fill + 1'b1;
                    end else begin
                        n_res_full = 1'b1;
                    end
                end
            end
            S_TALLY_RD: begin
            end
            S_TALLY_UPD: begin
                if (id_ok) begin
                    if (r_func == F_TALLY) begin
                        tally_we    = 1'b1;
                        tally_waddr = id_idx;
                        tally_wdata = tally_inc;
                        n_res_tally = tally_inc;
                    end else begin
                        n_res_tally = r_tally_rd;
                    end
                end
            end
            S_FINISH: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_seen      <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
            r_cmp_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_seen    <= n_seen;
            r_cmp_vld <= issue;
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_func      <= n_func;
        r_id        <= n_id;
        r_outline   <= n_outline;
        r_res_asg   <= n_res_asg;
        r_res_new   <= n_res_new;
        r_res_full  <= n_res_full;
        r_res_tally <= n_res_tally;
        r_cmp_idx   <= addr_idx;
        if (out_load) begin
            r_o_asg   <= r_res_asg;
            r_o_new   <= r_res_new;
            r_o_full  <= r_res_full;
            r_o_tally <= r_res_tally;
            r_o_used  <= used_ext[USED_W-1:0];
            r_o_seen  <= r_seen;
        end
    end

    // rectangle store: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (rect_we) rect_mem[fill_idx] <= r_outline;
        if (issue) r_rect_rd <= rect_mem[addr_idx];
    end

    always_ff @(posedge i_clk) begin
        if (tally_we) tally_mem[tally_waddr] <= tally_wdata;
        if ((r_state == S_TALLY_RD) && id_ok) r_tally_rd <= tally_mem[id_idx];
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_assigned_class = r_o_asg;
    assign o_new_class      = r_o_new;
    assign o_table_full     = r_o_full;
    assign o_tally          = r_o_tally;
    assign o_classes_used   = r_o_used;
    assign o_outlines_seen  = r_o_seen;

    `RCM_ASSERT_IMP(a_scan_drained, i_clk, i_rst_n, o_in_ready, !r_cmp_vld)
    `RCM_ASSERT_NXT(a_hit_finish, i_clk, i_rst_n, hit,
                    (r_state == S_FINISH) && !r_res_new && !r_res_full)
    `RCM_ASSERT_NXT(a_create_fill, i_clk, i_rst_n, rect_we,
                    r_fill == FILL_W'($past(r_fill) + 1'b1))

endmodule
